// File: sv/assert_macros.svh
// assertion macros shared by the lookup core modules
// expects clk_i and rst_ni in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define GFQL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// property that must never hold outside reset
`define GFQL_NEVER(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) else $error(msg);

`endif

// File: sv/gfql_pkg.sv
// types, constants and helpers of the quadrilinear grid lookup core
// no dependencies
package gfql_pkg;

  localparam int TIME_POINTS     = 16;
  localparam int X_POINTS        = 32;
  localparam int Y_POINTS        = 32;
  localparam int RAPIDITY_POINTS = 16;
  localparam int VALUE_BITS      = 16;

  localparam int AXES     = 4;
  localparam int FIELDS   = 5;
  localparam int ADDR_W   = 18;
  localparam int DEPTH    = 1 << ADDR_W;
  localparam int FIELD_W  = 16;
  localparam int COORD_W  = 32;
  localparam int INV_W    = 24;
  localparam int WGT_W    = 17;
  localparam int CORNERS  = 16;
  localparam int CNR_W    = 4;
  localparam int ACC_W    = 38;

  localparam int MAX_TX   = (TIME_POINTS > X_POINTS) ? TIME_POINTS : X_POINTS;
  localparam int MAX_YR   = (Y_POINTS > RAPIDITY_POINTS) ? Y_POINTS : RAPIDITY_POINTS;
  localparam int MAX_PTS  = (MAX_TX > MAX_YR) ? MAX_TX : MAX_YR;
  localparam int IDX_W    = $clog2(MAX_PTS);

  localparam logic [WGT_W-1:0] ONE_Q16 = WGT_W'(65536);

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_LOOKUP = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    CFG_TIME_ORIGIN,
    CFG_X_ORIGIN,
    CFG_Y_ORIGIN,
    CFG_RAP_ORIGIN,
    CFG_TIME_INV,
    CFG_X_INV,
    CFG_Y_INV,
    CFG_RAP_INV
  } cfg_idx_e;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_CLS,
    F_PUSH
  } fst_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_RUN,
    B_DRAIN
  } bst_e;

  typedef struct packed {
    op_e                                  op;
    logic [ADDR_W-1:0]                    addr;
    logic [FIELDS-1:0][FIELD_W-1:0]       data;
    logic [AXES-1:0][IDX_W-1:0]           lo;
    logic [AXES-1:0][WGT_W-1:0]           wh;
    logic                                 flag;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  function automatic int axis_points(input logic [1:0] a);
    int n;
    unique case (a)
      2'd0:    n = TIME_POINTS;
      2'd1:    n = X_POINTS;
      2'd2:    n = Y_POINTS;
      default: n = RAPIDITY_POINTS;
    endcase
    return n;
  endfunction

endpackage

// File: sv/gfql_front.sv
// front end: configuration registers, item capture and per-axis cell mapping
// depends on gfql_pkg
module gfql_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic                                opcode_i,
  input  logic [gfql_pkg::ADDR_W-1:0]         point_address_i,
  input  logic [gfql_pkg::FIELDS-1:0][gfql_pkg::FIELD_W-1:0] load_data_i,
  input  logic [gfql_pkg::AXES-1:0][gfql_pkg::COORD_W-1:0]   query_i,
  input  logic                                cfg_we_i,
  input  logic [2:0]                          cfg_index_i,
  input  logic [31:0]                         cfg_data_i,
  input  gfql_pkg::qstat_t                    qstat_i,
  output logic                                busy_o,
  output logic                                push_o,
  output gfql_pkg::entry_t                    entry_o
);

  gfql_pkg::fst_e state_q, state_d;
  logic [1:0] axis_q, axis_d;
  logic [gfql_pkg::AXES-1:0][gfql_pkg::COORD_W-1:0] origin_q;
  logic [gfql_pkg::AXES-1:0][gfql_pkg::INV_W-1:0]   inv_q;
  logic [gfql_pkg::AXES-1:0][gfql_pkg::COORD_W-1:0] query_q;
  gfql_pkg::entry_t ent_q;
  logic signed [57:0] prod_q;
  logic signed [32:0] diff;
  logic signed [57:0] prod_d;
  logic signed [25:0] cell_idx, last_lo, last_pt;
  logic [31:0] frac;
  logic [32:0] frac_rnd;
  logic [gfql_pkg::IDX_W-1:0] lo_v;
  logic [gfql_pkg::WGT_W-1:0] w_v;
  logic flag_v;
  logic accept;

  assign accept = start_i && (state_q == gfql_pkg::F_IDLE);
  assign busy_o = (state_q != gfql_pkg::F_IDLE);
  assign push_o = (state_q == gfql_pkg::F_PUSH) && !qstat_i.full;
  assign entry_o = ent_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_q[0] <= 32'd39322;
      origin_q[1] <= 32'hFFF5_3333;
      origin_q[2] <= 32'hFFF5_3333;
      origin_q[3] <= 32'hFFFB_3333;
      inv_q[0]    <= 24'd218453;
      inv_q[1]    <= 24'd218453;
      inv_q[2]    <= 24'd218453;
      inv_q[3]    <= 24'd218453;
    end else if (cfg_we_i) begin
      unique case (gfql_pkg::cfg_idx_e'(cfg_index_i))
        gfql_pkg::CFG_TIME_ORIGIN: origin_q[0] <= cfg_data_i;
        gfql_pkg::CFG_X_ORIGIN:    origin_q[1] <= cfg_data_i;
        gfql_pkg::CFG_Y_ORIGIN:    origin_q[2] <= cfg_data_i;
        gfql_pkg::CFG_RAP_ORIGIN:  origin_q[3] <= cfg_data_i;
        gfql_pkg::CFG_TIME_INV:    inv_q[0] <= cfg_data_i[gfql_pkg::INV_W-1:0];
        gfql_pkg::CFG_X_INV:       inv_q[1] <= cfg_data_i[gfql_pkg::INV_W-1:0];
        gfql_pkg::CFG_Y_INV:       inv_q[2] <= cfg_data_i[gfql_pkg::INV_W-1:0];
        default:                   inv_q[3] <= cfg_data_i[gfql_pkg::INV_W-1:0];
      endcase
    end
  end

  // scaled position of the current axis
  always_comb begin
    diff   = $signed({query_q[axis_q][31], query_q[axis_q]})
           - $signed({origin_q[axis_q][31], origin_q[axis_q]});
    prod_d = 58'(diff * $signed({1'b0, inv_q[axis_q]}));
  end

  // cell and upper weight from the registered product
  always_comb begin
    cell_idx = prod_q[57:32];
    frac     = prod_q[31:0];
    frac_rnd = {1'b0, frac} + 33'd32768;
    last_lo  = 26'(gfql_pkg::axis_points(axis_q) - 2);
    last_pt  = 26'(gfql_pkg::axis_points(axis_q) - 1);
    flag_v   = 1'b0;
    if (cell_idx < 0) begin
      lo_v   = '0;
      w_v    = '0;
      flag_v = 1'b1;
    end else if (cell_idx > last_lo) begin
      lo_v   = last_lo[gfql_pkg::IDX_W-1:0];
      w_v    = gfql_pkg::ONE_Q16;
      flag_v = !((cell_idx == last_pt) && (frac == 32'd0));
    end else begin
      lo_v   = cell_idx[gfql_pkg::IDX_W-1:0];
      w_v    = frac_rnd[32:16];
    end
  end

  always_comb begin
    state_d = state_q;
    axis_d  = axis_q;
    unique case (state_q)
      gfql_pkg::F_IDLE: begin
        if (start_i) begin
          axis_d  = 2'd0;
          state_d = (opcode_i == gfql_pkg::OP_LOOKUP) ? gfql_pkg::F_MUL : gfql_pkg::F_PUSH;
        end
      end
      gfql_pkg::F_MUL: state_d = gfql_pkg::F_CLS;
      gfql_pkg::F_CLS: begin
        if (axis_q == 2'd3) begin
          state_d = gfql_pkg::F_PUSH;
        end else begin
          axis_d  = axis_q + 2'd1;
          state_d = gfql_pkg::F_MUL;
        end
      end
      default: begin
        if (!qstat_i.full) begin
          state_d = gfql_pkg::F_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gfql_pkg::F_IDLE;
      axis_q  <= 2'd0;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ent_q.op   <= gfql_pkg::op_e'(opcode_i);
      ent_q.addr <= point_address_i;
      ent_q.data <= load_data_i;
      ent_q.flag <= 1'b0;
      query_q    <= query_i;
    end
    if (state_q == gfql_pkg::F_MUL) begin
      prod_q <= prod_d;
    end
    if (state_q == gfql_pkg::F_CLS) begin
      ent_q.lo[axis_q] <= lo_v;
      ent_q.wh[axis_q] <= w_v;
      ent_q.flag       <= ent_q.flag | flag_v;
    end
  end

endmodule

// File: sv/gfql_queue.sv
// two-entry queue between the front end and the back end
// depends on gfql_pkg and assert_macros.svh
`include "assert_macros.svh"
module gfql_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  gfql_pkg::entry_t entry_i,
  input  logic             pop_i,
  output gfql_pkg::entry_t entry_o,
  output gfql_pkg::qstat_t stat_o
);

  gfql_pkg::entry_t slot_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;

  assign entry_o      = slot_q[rp_q];
  assign stat_o.full  = (cnt_q == 2'd2);
  assign stat_o.empty = (cnt_q == 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wp_q <= !wp_q;
      end
      if (pop_i) begin
        rp_q <= !rp_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wp_q] <= entry_i;
    end
  end

  `GFQL_NEVER(a_push_full, push_i && stat_o.full, "push into full queue")
  `GFQL_NEVER(a_pop_empty, pop_i && stat_o.empty, "pop from empty queue")
  `GFQL_ASSERT(a_cnt_range, cnt_q != 2'd3, "queue count out of range")

endmodule

// File: sv/gfql_back.sv
// back end: grid memory, corner sequencer, weight pipeline and accumulators
// depends on gfql_pkg and assert_macros.svh
`include "assert_macros.svh"
module gfql_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  gfql_pkg::qstat_t        qstat_i,
  input  gfql_pkg::entry_t        entry_i,
  output logic                    pop_o,
  output logic                    done_o,
  output logic [gfql_pkg::FIELDS-1:0][gfql_pkg::FIELD_W-1:0] result_o,
  output logic                    out_of_grid_o
);

  localparam logic signed [gfql_pkg::ACC_W-1:0] SAT_HI =
    gfql_pkg::ACC_W'((64'd1 << (gfql_pkg::VALUE_BITS - 1)) - 64'd1);
  localparam logic signed [gfql_pkg::ACC_W-1:0] SAT_LO = -SAT_HI - 1;

  logic [gfql_pkg::FIELDS*gfql_pkg::FIELD_W-1:0] mem [gfql_pkg::DEPTH];

  gfql_pkg::bst_e state_q, state_d;
  gfql_pkg::entry_t cur_q;
  logic [gfql_pkg::CNR_W-1:0] iss_q;
  logic issue;

  logic [gfql_pkg::AXES-1:0][gfql_pkg::IDX_W-1:0] idx;
  logic [gfql_pkg::AXES-1:0][gfql_pkg::WGT_W-1:0] wt;
  logic [31:0] lin;
  logic [33:0] p1, p2, p3;

  logic va_q, vb_q, vc_q, vd_q;
  logic la_q, lb_q, lc_q, ld_q;
  logic fa_q, fb_q, fc_q, fd_q;
  logic [gfql_pkg::WGT_W-1:0] m1_q, m2_q, cw_q, w2a_q, w3a_q, w3b_q;
  logic [gfql_pkg::FIELDS*gfql_pkg::FIELD_W-1:0] rd_q, rdb_q, rdc_q;
  logic signed [33:0] prod_q [gfql_pkg::FIELDS];
  logic signed [gfql_pkg::ACC_W-1:0] acc_q [gfql_pkg::FIELDS];
  logic signed [gfql_pkg::ACC_W-1:0] acc_d [gfql_pkg::FIELDS];
  logic signed [gfql_pkg::ACC_W-1:0] rnd [gfql_pkg::FIELDS];
  logic signed [gfql_pkg::ACC_W-1:0] sat [gfql_pkg::FIELDS];
  logic fin;

  assign pop_o = (state_q == gfql_pkg::B_IDLE) && !qstat_i.empty;
  assign issue = (state_q == gfql_pkg::B_RUN);
  assign fin   = vd_q && ld_q;

  // corner indices, weights and linear address
  always_comb begin
    for (int a = 0; a < gfql_pkg::AXES; a++) begin
      idx[a] = cur_q.lo[a] + gfql_pkg::IDX_W'(iss_q[3-a]);
      wt[a]  = iss_q[3-a] ? cur_q.wh[a] : gfql_pkg::ONE_Q16 - cur_q.wh[a];
    end
    lin = ((32'(idx[0]) * 32'(gfql_pkg::X_POINTS) + 32'(idx[1]))
           * 32'(gfql_pkg::Y_POINTS) + 32'(idx[2]))
          * 32'(gfql_pkg::RAPIDITY_POINTS) + 32'(idx[3]);
    p1 = 34'(wt[0]) * 34'(wt[1]) + 34'd32768;
    p2 = 34'(m1_q) * 34'(w2a_q) + 34'd32768;
    p3 = 34'(m2_q) * 34'(w3b_q) + 34'd32768;
  end

  always_comb begin
    for (int k = 0; k < gfql_pkg::FIELDS; k++) begin
      acc_d[k] = (fd_q ? '0 : acc_q[k]) + gfql_pkg::ACC_W'(prod_q[k]);
      rnd[k]   = (acc_d[k] + gfql_pkg::ACC_W'(32768)) >>> 16;
      if (rnd[k] > SAT_HI) begin
        sat[k] = SAT_HI;
      end else if (rnd[k] < SAT_LO) begin
        sat[k] = SAT_LO;
      end else begin
        sat[k] = rnd[k];
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      gfql_pkg::B_IDLE: begin
        if (pop_o && (entry_i.op == gfql_pkg::OP_LOOKUP)) begin
          state_d = gfql_pkg::B_RUN;
        end
      end
      gfql_pkg::B_RUN: begin
        if (iss_q == gfql_pkg::CNR_W'(gfql_pkg::CORNERS - 1)) begin
          state_d = gfql_pkg::B_DRAIN;
        end
      end
      default: begin
        if (fin) begin
          state_d = gfql_pkg::B_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gfql_pkg::B_IDLE;
      iss_q   <= '0;
      va_q    <= 1'b0;
      vb_q    <= 1'b0;
      vc_q    <= 1'b0;
      vd_q    <= 1'b0;
      done_o  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (pop_o) begin
        iss_q <= '0;
      end else if (issue) begin
        iss_q <= iss_q + gfql_pkg::CNR_W'(1);
      end
      va_q   <= issue;
      vb_q   <= va_q;
      vc_q   <= vb_q;
      vd_q   <= vc_q;
      done_o <= fin;
    end
  end

  // grid memory
  always_ff @(posedge clk_i) begin
    if (pop_o && (entry_i.op == gfql_pkg::OP_WRITE)) begin
      mem[entry_i.addr] <= entry_i.data;
    end
    if (issue) begin
      rd_q <= mem[lin[gfql_pkg::ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= entry_i;
    end
    la_q  <= (iss_q == gfql_pkg::CNR_W'(gfql_pkg::CORNERS - 1));
    fa_q  <= (iss_q == '0);
    m1_q  <= p1[32:16];
    w2a_q <= wt[2];
    w3a_q <= wt[3];
    lb_q  <= la_q;
    fb_q  <= fa_q;
    m2_q  <= p2[32:16];
    w3b_q <= w3a_q;
    rdb_q <= rd_q;
    lc_q  <= lb_q;
    fc_q  <= fb_q;
    cw_q  <= p3[32:16];
    rdc_q <= rdb_q;
    ld_q  <= lc_q;
    fd_q  <= fc_q;
    for (int k = 0; k < gfql_pkg::FIELDS; k++) begin
      prod_q[k] <= 34'($signed(rdc_q[k*gfql_pkg::FIELD_W +: gfql_pkg::FIELD_W])
                   * $signed({1'b0, cw_q}));
      if (vd_q) begin
        acc_q[k] <= acc_d[k];
      end
      if (fin) begin
        result_o[k] <= sat[k][gfql_pkg::FIELD_W-1:0];
      end
    end
    if (fin) begin
      out_of_grid_o <= cur_q.flag;
    end
  end

  `GFQL_ASSERT(a_single_strobe, done_o |=> !done_o, "result strobe longer than one cycle")
  `GFQL_ASSERT(a_fin_drain, fin |-> (state_q == gfql_pkg::B_DRAIN), "last corner outside drain")
  `GFQL_NEVER(a_pop_busy, pop_o && (vb_q || vc_q || vd_q), "pop while corners in flight")

endmodule

// File: sv/grid_field_quadrilinear_lookup_core.sv
// Four-axis grid field lookup with quadrilinear interpolation.
// Channels: start_i/busy_o take one transaction when start_i is high and
// busy_o low. opcode_i 0 stores point_address_i with the five load fields;
// opcode 1 looks up query_* and yields one result.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_index_i at once
// (0..3 origins, 4..7 reciprocal spacings); write only while the core is idle.
// Results: done_o is high for one cycle with the five interpolated fields and
// out_of_grid_o; the receiver cannot stall, results are never held back.
// Flow: the front end maps one axis at a time, a multiply state (one 33x25
// multiply) then a cell state, and takes no new transaction until the
// current one is pushed, which waits while the queue is full. The back end
// reads the sixteen corners through one memory read port, one per cycle,
// and pops no entry until a lookup's last corner has drained. A two-entry
// queue between them lets stores and mappings run ahead of the corner sweep.
// Reset clears control state and the configuration registers to defaults;
// the grid memory is not cleared and must be written before it is read.
// depends on gfql_pkg, gfql_front, gfql_queue, gfql_back
module grid_field_quadrilinear_lookup_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  output logic         busy_o,
  input  logic         opcode_i,
  input  logic [17:0]  point_address_i,
  input  logic signed [15:0] load_temperature_i,
  input  logic signed [15:0] load_fraction_i,
  input  logic signed [15:0] load_vel_x_i,
  input  logic signed [15:0] load_vel_y_i,
  input  logic signed [15:0] load_vel_z_i,
  input  logic signed [31:0] query_time_i,
  input  logic signed [31:0] query_x_i,
  input  logic signed [31:0] query_y_i,
  input  logic signed [31:0] query_rapidity_i,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i,
  output logic         done_o,
  output logic signed [15:0] temperature_o,
  output logic signed [15:0] fraction_out_o,
  output logic signed [15:0] vel_x_o,
  output logic signed [15:0] vel_y_o,
  output logic signed [15:0] vel_z_o,
  output logic         out_of_grid_o
);

  logic [gfql_pkg::FIELDS-1:0][gfql_pkg::FIELD_W-1:0] load_data;
  logic [gfql_pkg::AXES-1:0][gfql_pkg::COORD_W-1:0]   query;
  logic [gfql_pkg::FIELDS-1:0][gfql_pkg::FIELD_W-1:0] result;
  gfql_pkg::entry_t push_entry, head_entry;
  gfql_pkg::qstat_t qstat;
  logic push, pop;

  assign load_data[0] = load_temperature_i;
  assign load_data[1] = load_fraction_i;
  assign load_data[2] = load_vel_x_i;
  assign load_data[3] = load_vel_y_i;
  assign load_data[4] = load_vel_z_i;
  assign query[0] = query_time_i;
  assign query[1] = query_x_i;
  assign query[2] = query_y_i;
  assign query[3] = query_rapidity_i;

  assign temperature_o  = result[0];
  assign fraction_out_o = result[1];
  assign vel_x_o        = result[2];
  assign vel_y_o        = result[3];
  assign vel_z_o        = result[4];

  gfql_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .opcode_i       (opcode_i),
    .point_address_i(point_address_i),
    .load_data_i    (load_data),
    .query_i        (query),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .qstat_i        (qstat),
    .busy_o         (busy_o),
    .push_o         (push),
    .entry_o        (push_entry)
  );

  gfql_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(push_entry),
    .pop_i  (pop),
    .entry_o(head_entry),
    .stat_o (qstat)
  );

  gfql_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .qstat_i      (qstat),
    .entry_i      (head_entry),
    .pop_o        (pop),
    .done_o       (done_o),
    .result_o     (result),
    .out_of_grid_o(out_of_grid_o)
  );

endmodule

// File: sim/grid_field_quadrilinear_lookup_core_tb.sv
// self-checking testbench of the quadrilinear grid lookup core
// drives stores and lookups through start/busy and checks every done_o strobe
// depends on gfql_pkg and grid_field_quadrilinear_lookup_core
`timescale 1ns / 1ps

module grid_field_quadrilinear_lookup_core_tb;

  localparam int LIMIT = 900000;

  typedef struct {
    gfql_pkg::op_e op;
    logic [17:0]  addr;
    logic [15:0]  load [5];
    logic [31:0]  query [4];
  } txn_t;

  typedef struct {
    logic [15:0] val [5];
    logic        oog;
  } lookup_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic opcode_i = 1'b0;
  logic [17:0] point_address_i = '0;
  logic signed [15:0] load_temperature_i = '0, load_fraction_i = '0, load_vel_x_i = '0;
  logic signed [15:0] load_vel_y_i = '0, load_vel_z_i = '0;
  logic signed [31:0] query_time_i = '0, query_x_i = '0, query_y_i = '0, query_rapidity_i = '0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic done_o;
  logic signed [15:0] temperature_o, fraction_out_o, vel_x_o, vel_y_o, vel_z_o;
  logic out_of_grid_o;

  grid_field_quadrilinear_lookup_core u_top (.*);

  always #5 clk_i = ~clk_i;

  logic [31:0] org_reg [4];
  logic [23:0] inv_reg [4];
  logic [79:0] grid_mem [gfql_pkg::DEPTH];
  bit          planned [gfql_pkg::DEPTH];
  txn_t        pending [$];
  lookup_res_t expected [$];
  txn_t        cur;
  int          idle_pct = 0;
  int          errors = 0;
  int          n_lookups = 0, n_stores = 0, n_flagged = 0;
  int          cycles = 0;

  function automatic int points_of(int a);
    case (a)
      0: return gfql_pkg::TIME_POINTS;
      1: return gfql_pkg::X_POINTS;
      2: return gfql_pkg::Y_POINTS;
      default: return gfql_pkg::RAPIDITY_POINTS;
    endcase
  endfunction

  function automatic void map_axis(input logic [31:0] q, input int a, output int lo,
                                   output longint w, output bit fl);
    longint s, i, f;
    int n;
    n = points_of(a);
    s = (longint'($signed(q)) - longint'($signed(org_reg[a]))) * longint'({40'b0, inv_reg[a]});
    i = s >>> 32;
    f = longint'({32'b0, s[31:0]});
    fl = 1'b0;
    if (i < 0) begin
      lo = 0; w = 0; fl = 1'b1;
    end else if (i > n - 2) begin
      lo = n - 2; w = 65536;
      if (!(i == n - 1 && f == 0)) fl = 1'b1;
    end else begin
      lo = int'(i); w = (f + 32768) >> 16;
    end
  endfunction

  function automatic logic [17:0] corner_addr(int lo [4], int c);
    int idx [4];
    for (int a = 0; a < 4; a++) idx[a] = lo[a] + ((c >> (3 - a)) & 1);
    return 18'((((idx[0] * gfql_pkg::X_POINTS + idx[1]) * gfql_pkg::Y_POINTS + idx[2])
                * gfql_pkg::RAPIDITY_POINTS) + idx[3]);
  endfunction

  function automatic bit corners_written(logic [31:0] q [4]);
    int lo [4];
    longint w;
    bit fl;
    for (int a = 0; a < 4; a++) map_axis(q[a], a, lo[a], w, fl);
    for (int c = 0; c < 16; c++) if (!planned[corner_addr(lo, c)]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic lookup_res_t interpolate(logic [31:0] q [4]);
    int lo [4];
    longint wh [4], wt [4], acc [5], cw, r, hi;
    bit fl, any;
    logic [79:0] ent;
    lookup_res_t res;
    any = 1'b0;
    hi = (longint'(1) << (gfql_pkg::VALUE_BITS - 1)) - 1;
    for (int a = 0; a < 4; a++) begin
      map_axis(q[a], a, lo[a], wh[a], fl);
      any |= fl;
    end
    for (int k = 0; k < 5; k++) acc[k] = 0;
    for (int c = 0; c < 16; c++) begin
      for (int a = 0; a < 4; a++) wt[a] = ((c >> (3 - a)) & 1) ? wh[a] : 65536 - wh[a];
      cw = (wt[0] * wt[1] + 32768) >> 16;
      cw = (cw * wt[2] + 32768) >> 16;
      cw = (cw * wt[3] + 32768) >> 16;
      ent = grid_mem[corner_addr(lo, c)];
      for (int k = 0; k < 5; k++) acc[k] += longint'($signed(ent[k*16 +: 16])) * cw;
    end
    for (int k = 0; k < 5; k++) begin
      r = (acc[k] + 32768) >>> 16;
      if (r > hi) r = hi;
      if (r < -hi - 1) r = -hi - 1;
      res.val[k] = r[15:0];
    end
    res.oog = any;
    return res;
  endfunction

  // driver
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        if (cur.op == gfql_pkg::OP_WRITE) begin
          grid_mem[cur.addr] = {cur.load[4], cur.load[3], cur.load[2], cur.load[1], cur.load[0]};
          n_stores++;
        end else begin
          expected.push_back(interpolate(cur.query));
          n_lookups++;
        end
      end
      if (!start_i || !busy_o) begin
        if (pending.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
          cur = pending.pop_front();
          opcode_i <= cur.op;
          point_address_i <= cur.addr;
          load_temperature_i <= cur.load[0];
          load_fraction_i <= cur.load[1];
          load_vel_x_i <= cur.load[2];
          load_vel_y_i <= cur.load[3];
          load_vel_z_i <= cur.load[4];
          query_time_i <= cur.query[0];
          query_x_i <= cur.query[1];
          query_y_i <= cur.query[2];
          query_rapidity_i <= cur.query[3];
          start_i <= 1'b1;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    lookup_res_t e;
    logic [15:0] got [5];
    bit bad;
    if (rst_ni && done_o) begin
      got = '{temperature_o, fraction_out_o, vel_x_o, vel_y_o, vel_z_o};
      if (expected.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result transaction");
      end else begin
        e = expected.pop_front();
        bad = (e.oog !== out_of_grid_o);
        for (int k = 0; k < 5; k++) bad |= (e.val[k] !== got[k]);
        if (e.oog) n_flagged++;
        if (bad) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp %h %h %h %h %h oog %b, got %h %h %h %h %h oog %b",
                     e.val[0], e.val[1], e.val[2], e.val[3], e.val[4], e.oog,
                     got[0], got[1], got[2], got[3], got[4], out_of_grid_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycles > LIMIT) begin
      $display("[grid_field_quadrilinear_lookup_core] ERROR");
      $finish;
    end
  end

  task automatic write_reg(gfql_pkg::cfg_idx_e idx, logic [31:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    if (idx < gfql_pkg::CFG_TIME_INV) org_reg[idx] = data;
    else inv_reg[idx - gfql_pkg::CFG_TIME_INV] = data[23:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_regs(logic [31:0] o [4], logic [23:0] v [4]);
    for (int a = 0; a < 4; a++) write_reg(gfql_pkg::cfg_idx_e'(a), o[a]);
    for (int a = 0; a < 4; a++) write_reg(gfql_pkg::cfg_idx_e'(a + 4), {8'b0, v[a]});
  endtask

  task automatic drain();
    while (pending.size() != 0 || start_i || expected.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  function automatic txn_t rand_txn(gfql_pkg::op_e op);
    txn_t t;
    t.op = op;
    t.addr = 18'($urandom);
    for (int k = 0; k < 5; k++) t.load[k] = 16'($urandom);
    for (int a = 0; a < 4; a++) t.query[a] = $urandom;
    return t;
  endfunction

  task automatic push_store(logic [17:0] addr);
    txn_t t;
    t = rand_txn(gfql_pkg::OP_WRITE);
    t.addr = addr;
    planned[addr] = 1'b1;
    pending.push_back(t);
  endtask

  task automatic push_lookup(logic [31:0] q [4]);
    txn_t t;
    t = rand_txn(gfql_pkg::OP_LOOKUP);
    t.query = q;
    pending.push_back(t);
  endtask

  task automatic random_phase(int count);
    txn_t t;
    logic [31:0] q [4];
    longint off;
    int sel, tries;
    for (int n = 0; n < count; n++) begin
      if (n % 100 == 0) idle_pct = (n / 100) % 4 == 1 ? 47 : (n / 100) % 4 == 3 ? 36 : 0;
      if ($urandom_range(0, 99) < 40) begin
        if ($urandom_range(0, 9) == 0) push_store(18'($urandom));
        else push_store(18'(((($urandom_range(0, 3) * gfql_pkg::X_POINTS
                                + $urandom_range(0, 7)) * gfql_pkg::Y_POINTS
                               + $urandom_range(0, 7)) * gfql_pkg::RAPIDITY_POINTS)
                            + $urandom_range(0, 3)));
      end else begin
        tries = 0;
        do begin
          sel = $urandom_range(0, 9);
          for (int a = 0; a < 4; a++) begin
            if (sel < 2) q[a] = $urandom;
            else if (sel < 4 || inv_reg[a] == 0)
              q[a] = org_reg[a] + 32'($signed(18'($urandom)));
            else begin
              off = ((longint'($urandom_range(0, 4)) << 32) + longint'($urandom)
                     - (longint'(1) << 31)) / longint'({40'b0, inv_reg[a]});
              q[a] = org_reg[a] + 32'(off);
            end
          end
          tries++;
        end while (!corners_written(q) && tries < 20);
        if (!corners_written(q)) q = org_reg;
        push_lookup(q);
      end
    end
    drain();
  endtask

  initial begin
    logic [31:0] o [4];
    logic [23:0] v [4];
    logic [31:0] q [4];
    int e [4];
    org_reg = '{32'd39322, -32'sd707789, -32'sd707789, -32'sd314573};
    inv_reg = '{24'd218453, 24'd218453, 24'd218453, 24'd218453};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // edge cells of every axis, so clamped lookups read written points only
    for (int c = 0; c < 256; c++) begin
      for (int a = 0; a < 4; a++) begin
        e[a] = (c >> (2 * a)) & 3;
        e[a] = e[a] < 2 ? e[a] : points_of(a) - 4 + e[a];
      end
      push_store(18'((((e[0] * gfql_pkg::X_POINTS + e[1]) * gfql_pkg::Y_POINTS + e[2])
                      * gfql_pkg::RAPIDITY_POINTS) + e[3]));
    end
    pending[0].load = '{16'h7fff, 16'h8000, 16'h0000, 16'hffff, 16'h0001};
    pending[1].load = '{16'h8000, 16'h7fff, 16'hffff, 16'h0000, 16'h7fff};
    drain();

    // directed lookups with unit spacing and zero origins
    o = '{32'd0, 32'd0, 32'd0, 32'd0};
    v = '{24'd65536, 24'd65536, 24'd65536, 24'd65536};
    set_regs(o, v);
    push_lookup('{32'd0, 32'd0, 32'd0, 32'd0});
    push_lookup('{32'd15 << 16, 32'd31 << 16, 32'd31 << 16, 32'd15 << 16});
    push_lookup('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
    push_lookup('{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff});
    push_lookup('{32'h0000_8000, 32'h0000_4000, 32'h0000_c000, 32'h0000_0001});
    push_lookup('{32'h000e_8000, 32'h001f_0001, 32'h0000_7fff, 32'hffff_ffff});
    push_lookup('{32'h000f_0000, 32'h0000_0000, 32'h001f_0000, 32'h0000_0000});
    drain();

    random_phase(300);
    v = '{24'd0, 24'd0, 24'd0, 24'd0};
    set_regs(o, v);
    push_lookup('{32'h1234_5678, 32'h8000_0000, 32'h7fff_ffff, 32'd0});
    random_phase(120);
    o = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
    v = '{24'hff_ffff, 24'hff_ffff, 24'hff_ffff, 24'hff_ffff};
    set_regs(o, v);
    random_phase(250);
    o = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff};
    v = '{24'd1, 24'd2, 24'd3, 24'd4};
    set_regs(o, v);
    random_phase(200);
    for (int a = 0; a < 4; a++) begin
      o[a] = $urandom;
      v[a] = 24'($urandom_range(1 << 14, 1 << 20));
    end
    set_regs(o, v);
    random_phase(400);
    o = '{32'd39322, -32'sd707789, -32'sd707789, -32'sd314573};
    v = '{24'd218453, 24'd218453, 24'd218453, 24'd218453};
    set_regs(o, v);
    random_phase(450);

    errors += expected.size();
    $display("covered %0d stores and %0d lookups over six register settings", n_stores, n_lookups);
    $display("%0d lookups flagged out of grid, %0d failures", n_flagged, errors);
    if (errors == 0) begin
      $display("[grid_field_quadrilinear_lookup_core] OK");
    end else begin
      $display("[grid_field_quadrilinear_lookup_core] ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+sv
sv/gfql_pkg.sv
sv/gfql_front.sv
sv/gfql_queue.sv
sv/gfql_back.sv
sv/grid_field_quadrilinear_lookup_core.sv
sim/grid_field_quadrilinear_lookup_core_tb.sv
